/* src/lgia_pkg.sv */
// Shared types and constants for the linear gradient intensity adder.
`timescale 1ns / 1ps

package lgia_pkg;

   localparam int PIXEL_W  = 8;
   localparam int POS_W    = 12;
   localparam int COORD_W  = 14;
   localparam int OFFSET_W = 9;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 14;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_X      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_Y      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_X        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_Y        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_OFFSET = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_OFFSET   = 3'd5;

   localparam int DIFF_W = 15;
   localparam int GAIN_W = 10;
   localparam int BASE_W = 10;
   localparam int PROD_W = 30;
   localparam int PROJ_W = 31;
   localparam int DEN_W  = 30;
   localparam int NUM_W  = 41;
   localparam int QUO_W  = 10;
   localparam int MAG_W  = DEN_W + QUO_W;
   localparam int SUM_W  = 12;

   localparam logic signed [SUM_W-1:0] QUO_SAT_POS = 12'sd1023;
   localparam logic signed [SUM_W-1:0] QUO_SAT_NEG = -12'sd1024;
   localparam logic signed [SUM_W-1:0] PIXEL_MAX   = 12'sd255;

   localparam int FRONT_DEPTH = 4;
   localparam int DIV_DEPTH   = QUO_W + 2;
   localparam int PIPE_DEPTH  = FRONT_DEPTH + DIV_DEPTH + 1;

   typedef struct packed {
      logic signed [COORD_W-1:0]  start_x;
      logic signed [COORD_W-1:0]  start_y;
      logic signed [COORD_W-1:0]  end_x;
      logic signed [COORD_W-1:0]  end_y;
      logic signed [OFFSET_W-1:0] start_offset;
      logic signed [OFFSET_W-1:0] end_offset;
   } cfg_type;

   typedef struct packed {
      logic signed [BASE_W-1:0] base;
      logic                     zero;
      logic [DEN_W-1:0]         den;
      logic signed [NUM_W-1:0]  num;
   } quot_req_type;

   typedef struct packed {
      logic                     neg;
      logic                     zero;
      logic                     sat;
      logic signed [BASE_W-1:0] base;
      logic [DEN_W-1:0]         den;
      logic [MAG_W-1:0]         rem;
      logic [QUO_W-1:0]         quo;
   } div_work_type;

endpackage

/* src/linear_gradient_intensity_add.sv */
// Top level of the linear gradient intensity adder for one colour channel.
`timescale 1ns / 1ps

// Adds a linear gradient offset to a stream of 8-bit pixels of one channel.
// Request channel req_*: one pixel with its row and column per transaction,
// taken when req_valid is high and req_stall is low.
// Response channel rsp_*: one adjusted pixel per request, in request order,
// taken when rsp_valid is high and rsp_stall is low.
// Configuration channel csr_*: register index and data, written when
// csr_valid and csr_ready are high; csr_ready is always high. Registers are
// start_x, start_y, end_x, end_y, start_offset, end_offset (indexes 0 to 5);
// other indexes are ignored. Write them only while no transaction is in flight.
// From request to response a transaction passes four stages of offsets,
// products, projection and scaled numerator, a magnitude stage, a range check
// stage, ten restoring division stages (one quotient bit each), and the output register.
// Throughput is one pixel per cycle while no stall holds the pipeline; every stage carries its own valid bit.
// While rsp_stall is high the output holds and empty stages behind it still
// fill, so up to 17 transactions are held before req_stall rises.
// Synchronous reset empties the pipeline and loads the register reset values.
module linear_gradient_intensity_add #(
   parameter int MAX_DIM = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lgia_pkg::PIXEL_W-1:0]        req_pixel_in,
   input  logic [lgia_pkg::POS_W-1:0]          req_row,
   input  logic [lgia_pkg::POS_W-1:0]          req_column,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lgia_pkg::PIXEL_W-1:0]        rsp_pixel_out,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lgia_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lgia_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int QuoPadW = lgia_pkg::SUM_W - lgia_pkg::QUO_W;

   lgia_pkg::cfg_type       cfg_in, cfg_ff;
   logic                    front_ready;
   logic                    front_valid, div_ready;
   lgia_pkg::quot_req_type  front_data;
   logic                    div_valid, out_ready;
   lgia_pkg::div_work_type  div_work;

   logic signed [lgia_pkg::SUM_W-1:0] quo_mag, quo_round, quo_val, sum;
   logic [lgia_pkg::PIXEL_W-1:0]      pixel_out_in, pixel_out_ff;
   logic                              rsp_valid_ff;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            lgia_pkg::CSR_START_X: begin
               cfg_in.start_x = csr_data[lgia_pkg::COORD_W-1:0];
            end
            lgia_pkg::CSR_START_Y: begin
               cfg_in.start_y = csr_data[lgia_pkg::COORD_W-1:0];
            end
            lgia_pkg::CSR_END_X: begin
               cfg_in.end_x = csr_data[lgia_pkg::COORD_W-1:0];
            end
            lgia_pkg::CSR_END_Y: begin
               cfg_in.end_y = csr_data[lgia_pkg::COORD_W-1:0];
            end
            lgia_pkg::CSR_START_OFFSET: begin
               cfg_in.start_offset = csr_data[lgia_pkg::OFFSET_W-1:0];
            end
            lgia_pkg::CSR_END_OFFSET: begin
               cfg_in.end_offset = csr_data[lgia_pkg::OFFSET_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_x      <= '0;
         cfg_ff.start_y      <= '0;
         cfg_ff.end_x        <= lgia_pkg::COORD_W'(1);
         cfg_ff.end_y        <= '0;
         cfg_ff.start_offset <= '0;
         cfg_ff.end_offset   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lgia_front #(
      .MAX_DIM(MAX_DIM)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .pixel_in  (req_pixel_in),
      .row       (req_row),
      .column    (req_column),
      .out_valid (front_valid),
      .out_ready (div_ready),
      .out_data  (front_data)
   );

   lgia_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (div_ready),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_ready (out_ready),
      .out_work  (div_work)
   );

   assign req_stall = !front_ready;
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      quo_mag   = $signed({{QuoPadW{1'b0}}, div_work.quo});
      quo_round = $signed({{(lgia_pkg::SUM_W-1){1'b0}}, |div_work.rem});
      if (div_work.zero) begin
         quo_val = '0;
      end else if (div_work.sat) begin
         quo_val = div_work.neg ? lgia_pkg::QUO_SAT_NEG : lgia_pkg::QUO_SAT_POS;
      end else if (div_work.neg) begin
         quo_val = -quo_mag - quo_round;
      end else begin
         quo_val = quo_mag;
      end
      sum = lgia_pkg::SUM_W'(div_work.base) + quo_val;
      if (sum < 0) begin
         pixel_out_in = '0;
      end else if (sum > lgia_pkg::PIXEL_MAX) begin
         pixel_out_in = lgia_pkg::PIXEL_MAX[lgia_pkg::PIXEL_W-1:0];
      end else begin
         pixel_out_in = sum[lgia_pkg::PIXEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         pixel_out_ff <= pixel_out_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = pixel_out_ff;

endmodule

/* src/lgia_front.sv */
// Front pipeline: position offsets, products, projection and scaled numerator.
`timescale 1ns / 1ps

module lgia_front #(
   parameter int MAX_DIM = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lgia_pkg::cfg_type              cfg,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [lgia_pkg::PIXEL_W-1:0]   pixel_in,
   input  logic [lgia_pkg::POS_W-1:0]     row,
   input  logic [lgia_pkg::POS_W-1:0]     column,
   output logic                           out_valid,
   input  logic                           out_ready,
   output lgia_pkg::quot_req_type         out_data
);

   localparam int PosMax = (1 << lgia_pkg::POS_W) - 1;
   localparam int LimInt = (MAX_DIM - 1 > PosMax) ? PosMax : MAX_DIM - 1;
   localparam logic [lgia_pkg::POS_W-1:0] COORD_LIM = lgia_pkg::POS_W'(LimInt);
   localparam int PadW = lgia_pkg::DIFF_W - lgia_pkg::POS_W;
   localparam int PixPadW = lgia_pkg::BASE_W - lgia_pkg::PIXEL_W;

   logic rdy1, rdy2, rdy3, rdy4;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   logic [lgia_pkg::POS_W-1:0] row_sat, col_sat;

   logic signed [lgia_pkg::DIFF_W-1:0] px1_in, py1_in, dx1_in, dy1_in;
   logic signed [lgia_pkg::DIFF_W-1:0] px1_ff, py1_ff, dx1_ff, dy1_ff;
   logic signed [lgia_pkg::GAIN_W-1:0] gain1_in, gain1_ff, gain2_ff, gain3_ff;
   logic signed [lgia_pkg::BASE_W-1:0] base1_in, base1_ff, base2_ff, base3_ff, base4_ff;

   logic signed [lgia_pkg::PROD_W-1:0] tx2_in, ty2_in, dxx2_in, dyy2_in;
   logic signed [lgia_pkg::PROD_W-1:0] tx2_ff, ty2_ff, dxx2_ff, dyy2_ff;

   logic signed [lgia_pkg::PROJ_W-1:0] t3_in, t3_ff, den_sum;
   logic [lgia_pkg::DEN_W-1:0]         den3_in, den3_ff, den4_ff;

   logic signed [lgia_pkg::NUM_W-1:0]  num4_in, num4_ff;
   logic                               zero4_in, zero4_ff;

   assign rdy4     = !v4_ff || out_ready;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      row_sat  = (row > COORD_LIM) ? COORD_LIM : row;
      col_sat  = (column > COORD_LIM) ? COORD_LIM : column;
      px1_in   = $signed({{PadW{1'b0}}, col_sat}) - lgia_pkg::DIFF_W'(cfg.start_x);
      py1_in   = $signed({{PadW{1'b0}}, row_sat}) - lgia_pkg::DIFF_W'(cfg.start_y);
      dx1_in   = lgia_pkg::DIFF_W'(cfg.end_x) - lgia_pkg::DIFF_W'(cfg.start_x);
      dy1_in   = lgia_pkg::DIFF_W'(cfg.end_y) - lgia_pkg::DIFF_W'(cfg.start_y);
      gain1_in = lgia_pkg::GAIN_W'(cfg.end_offset) - lgia_pkg::GAIN_W'(cfg.start_offset);
      base1_in = lgia_pkg::BASE_W'(cfg.start_offset)
                 + $signed({{PixPadW{1'b0}}, pixel_in});
   end

   always_comb begin
      tx2_in  = lgia_pkg::PROD_W'(px1_ff) * lgia_pkg::PROD_W'(dx1_ff);
      ty2_in  = lgia_pkg::PROD_W'(py1_ff) * lgia_pkg::PROD_W'(dy1_ff);
      dxx2_in = lgia_pkg::PROD_W'(dx1_ff) * lgia_pkg::PROD_W'(dx1_ff);
      dyy2_in = lgia_pkg::PROD_W'(dy1_ff) * lgia_pkg::PROD_W'(dy1_ff);
   end

   always_comb begin
      t3_in   = lgia_pkg::PROJ_W'(tx2_ff) + lgia_pkg::PROJ_W'(ty2_ff);
      den_sum = lgia_pkg::PROJ_W'(dxx2_ff) + lgia_pkg::PROJ_W'(dyy2_ff);
      den3_in = den_sum[lgia_pkg::DEN_W-1:0];
   end

   always_comb begin
      num4_in  = lgia_pkg::NUM_W'(gain3_ff) * lgia_pkg::NUM_W'(t3_ff);
      zero4_in = (den3_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         px1_ff   <= px1_in;
         py1_ff   <= py1_in;
         dx1_ff   <= dx1_in;
         dy1_ff   <= dy1_in;
         gain1_ff <= gain1_in;
         base1_ff <= base1_in;
      end
      if (rdy2) begin
         tx2_ff   <= tx2_in;
         ty2_ff   <= ty2_in;
         dxx2_ff  <= dxx2_in;
         dyy2_ff  <= dyy2_in;
         gain2_ff <= gain1_ff;
         base2_ff <= base1_ff;
      end
      if (rdy3) begin
         t3_ff    <= t3_in;
         den3_ff  <= den3_in;
         gain3_ff <= gain2_ff;
         base3_ff <= base2_ff;
      end
      if (rdy4) begin
         num4_ff  <= num4_in;
         zero4_ff <= zero4_in;
         den4_ff  <= den3_ff;
         base4_ff <= base3_ff;
      end
   end

   assign out_valid     = v4_ff;
   assign out_data.base = base4_ff;
   assign out_data.zero = zero4_ff;
   assign out_data.den  = den4_ff;
   assign out_data.num  = num4_ff;

endmodule

/* src/lgia_div_step.sv */
// One restoring division step: produces one quotient bit per stage.
`timescale 1ns / 1ps

module lgia_div_step #(
   parameter int SHIFT = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  lgia_pkg::div_work_type in_work,
   output logic                   out_valid,
   input  logic                   out_ready,
   output lgia_pkg::div_work_type out_work
);

   logic                          v_ff;
   logic [lgia_pkg::MAG_W-1:0]    divisor;
   lgia_pkg::div_work_type        work_in, work_ff;

   assign in_ready = !v_ff || out_ready;

   always_comb begin
      divisor = {{lgia_pkg::QUO_W{1'b0}}, in_work.den} << SHIFT;
      work_in = in_work;
      if (in_work.rem >= divisor) begin
         work_in.rem        = in_work.rem - divisor;
         work_in.quo[SHIFT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = v_ff;
   assign out_work  = work_ff;

endmodule

/* src/lgia_div.sv */
// Pipelined floor divider: magnitude, range check and restoring steps.
`timescale 1ns / 1ps

module lgia_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  lgia_pkg::quot_req_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output lgia_pkg::div_work_type out_work
);

   logic                   rdy_a, rdy_b;
   logic                   va_ff, vb_ff;
   lgia_pkg::div_work_type wa_in, wa_ff, wb_in, wb_ff;

   logic                   step_valid [lgia_pkg::QUO_W+1];
   logic                   step_ready [lgia_pkg::QUO_W+1];
   lgia_pkg::div_work_type step_work  [lgia_pkg::QUO_W+1];

   assign rdy_b    = !vb_ff || step_ready[0];
   assign rdy_a    = !va_ff || rdy_b;
   assign in_ready = rdy_a;

   always_comb begin
      wa_in      = '0;
      wa_in.neg  = in_data.num[lgia_pkg::NUM_W-1];
      wa_in.zero = in_data.zero;
      wa_in.base = in_data.base;
      wa_in.den  = in_data.den;
      wa_in.rem  = in_data.num[lgia_pkg::NUM_W-1]
                   ? lgia_pkg::MAG_W'(-in_data.num)
                   : lgia_pkg::MAG_W'(in_data.num);
   end

   always_comb begin
      wb_in     = wa_ff;
      wb_in.sat = (wa_ff.rem >= {wa_ff.den, {lgia_pkg::QUO_W{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (rdy_a) va_ff <= in_valid;
         if (rdy_b) vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) wa_ff <= wa_in;
      if (rdy_b) wb_ff <= wb_in;
   end

   assign step_valid[0] = vb_ff;
   assign step_work[0]  = wb_ff;

   for (genvar s = 0; s < lgia_pkg::QUO_W; s++) begin : g_step
      lgia_div_step #(
         .SHIFT(lgia_pkg::QUO_W - 1 - s)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (step_valid[s]),
         .in_ready  (step_ready[s]),
         .in_work   (step_work[s]),
         .out_valid (step_valid[s+1]),
         .out_ready (step_ready[s+1]),
         .out_work  (step_work[s+1])
      );
   end

   assign step_ready[lgia_pkg::QUO_W] = out_ready;
   assign out_valid = step_valid[lgia_pkg::QUO_W];
   assign out_work  = step_work[lgia_pkg::QUO_W];

endmodule

/* src/lgia_checker.sv */
// Port-level checker for the linear gradient intensity adder, with its bind.
`timescale 1ns / 1ps

module lgia_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [lgia_pkg::PIXEL_W-1:0]      rsp_pixel_out
);

   localparam int CntW = $clog2(lgia_pkg::PIPE_DEPTH + 1);
   localparam logic [CntW-1:0] CNT_MAX = CntW'(lgia_pkg::PIPE_DEPTH);

   logic            req_take, rsp_take;
   logic [CntW-1:0] inflight_in, inflight_ff;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_take && !rsp_take) begin
         inflight_in = inflight_ff + CntW'(1);
      end else if (rsp_take && !req_take) begin
         inflight_in = inflight_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response withdrawn while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_pixel_out))
      else $error("response payload changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != '0)
      else $error("response without an outstanding request");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= CNT_MAX)
      else $error("more transactions in flight than pipeline stages");

endmodule

bind linear_gradient_intensity_add lgia_checker u_lgia_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_pixel_out (rsp_pixel_out)
);

/* tb/sv/tb_linear_gradient_intensity_add.sv */
// Self-checking testbench for the linear gradient intensity adder, one colour channel.
`timescale 1ns / 1ps

module tb_linear_gradient_intensity_add;

   localparam logic [lgia_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [lgia_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam int RANDOM_PHASES = 14;
   localparam int PHASE_ITEMS   = 125;

   typedef struct {
      logic [lgia_pkg::PIXEL_W-1:0] pixel;
      logic [lgia_pkg::POS_W-1:0]   row;
      logic [lgia_pkg::POS_W-1:0]   column;
   } pixel_req_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [lgia_pkg::PIXEL_W-1:0]     req_pixel_in = '0;
   logic [lgia_pkg::POS_W-1:0]       req_row = '0;
   logic [lgia_pkg::POS_W-1:0]       req_column = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [lgia_pkg::PIXEL_W-1:0]     rsp_pixel_out;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [lgia_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [lgia_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   lgia_pkg::cfg_type            gradient;
   pixel_req_type                pending_reqs[$];
   logic [lgia_pkg::PIXEL_W-1:0] expected_pixels[$];
   logic [lgia_pkg::PIXEL_W-1:0] want_pixel;
   pixel_req_type                next_req;
   logic                         req_taken = 1'b0;
   int                           accepted_count = 0;
   int                           error_count = 0;
   bit                           hold_started = 1'b0;
   int                           hold_left = 0;

   linear_gradient_intensity_add dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pixel_in(req_pixel_in),
      .req_row(req_row),
      .req_column(req_column),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pixel_out(rsp_pixel_out),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   function automatic logic [lgia_pkg::PIXEL_W-1:0] gradient_pixel(
         lgia_pkg::cfg_type g, logic [lgia_pkg::PIXEL_W-1:0] pix,
         logic [lgia_pkg::POS_W-1:0] row, logic [lgia_pkg::POS_W-1:0] column);
      longint dx, dy, span, proj, num, quo, lift, total;
      dx   = longint'($signed(g.end_x)) - longint'($signed(g.start_x));
      dy   = longint'($signed(g.end_y)) - longint'($signed(g.start_y));
      span = dx * dx + dy * dy;
      lift = longint'($signed(g.start_offset));
      if (span != 0) begin
         proj = (longint'(column) - longint'($signed(g.start_x))) * dx
              + (longint'(row) - longint'($signed(g.start_y))) * dy;
         num  = (longint'($signed(g.end_offset)) - lift) * proj;
         quo  = num / span;
         if (num % span != 0 && num < 0)
            quo = quo - 1;
         lift = lift + quo;
      end
      total = longint'(pix) + lift;
      if (total < 0)
         total = 0;
      if (total > 255)
         total = 255;
      return total[lgia_pkg::PIXEL_W-1:0];
   endfunction

   function automatic void apply_csr(logic [lgia_pkg::CSR_INDEX_W-1:0] index,
                                     logic [lgia_pkg::CSR_DATA_W-1:0] data);
      case (index)
         lgia_pkg::CSR_START_X:      gradient.start_x = data;
         lgia_pkg::CSR_START_Y:      gradient.start_y = data;
         lgia_pkg::CSR_END_X:        gradient.end_x = data;
         lgia_pkg::CSR_END_Y:        gradient.end_y = data;
         lgia_pkg::CSR_START_OFFSET: gradient.start_offset = data[lgia_pkg::OFFSET_W-1:0];
         lgia_pkg::CSR_END_OFFSET:   gradient.end_offset = data[lgia_pkg::OFFSET_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic int idle_pct();
      return (accepted_count >= 700 && accepted_count < 1000) ? 0 : 14;
   endfunction

   function automatic void add_req(logic [lgia_pkg::PIXEL_W-1:0] pixel,
                                   logic [lgia_pkg::POS_W-1:0] row,
                                   logic [lgia_pkg::POS_W-1:0] column);
      pixel_req_type r;
      r.pixel  = pixel;
      r.row    = row;
      r.column = column;
      pending_reqs.push_back(r);
   endfunction

   function automatic logic [lgia_pkg::POS_W-1:0] random_pos();
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(0, 1) ? '1 : '0;
      return lgia_pkg::POS_W'($urandom);
   endfunction

   function automatic void add_random_req();
      logic [lgia_pkg::PIXEL_W-1:0] pixel;
      pixel = lgia_pkg::PIXEL_W'($urandom);
      if ($urandom_range(0, 7) == 0)
         pixel = $urandom_range(0, 1) ? '1 : '0;
      add_req(pixel, random_pos(), random_pos());
   endfunction

   task automatic write_csr(logic [lgia_pkg::CSR_INDEX_W-1:0] index,
                            logic [lgia_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do
         @(posedge clock);
      while (!csr_ready);
      apply_csr(index, data);
   endtask

   task automatic write_gradient(logic [lgia_pkg::COORD_W-1:0] sx,
                                 logic [lgia_pkg::COORD_W-1:0] sy,
                                 logic [lgia_pkg::COORD_W-1:0] ex,
                                 logic [lgia_pkg::COORD_W-1:0] ey,
                                 logic [lgia_pkg::OFFSET_W-1:0] so,
                                 logic [lgia_pkg::OFFSET_W-1:0] eo);
      write_csr(lgia_pkg::CSR_START_X, sx);
      write_csr(lgia_pkg::CSR_START_Y, sy);
      write_csr(lgia_pkg::CSR_END_X, ex);
      write_csr(lgia_pkg::CSR_END_Y, ey);
      write_csr(lgia_pkg::CSR_START_OFFSET, {5'($urandom), so});
      write_csr(lgia_pkg::CSR_END_OFFSET, {5'($urandom), eo});
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_gradient();
      logic [lgia_pkg::COORD_W-1:0]  sx, sy, ex, ey;
      logic [lgia_pkg::OFFSET_W-1:0] so, eo;
      sx = lgia_pkg::COORD_W'($urandom);
      sy = lgia_pkg::COORD_W'($urandom);
      ex = lgia_pkg::COORD_W'($urandom);
      ey = lgia_pkg::COORD_W'($urandom);
      case ($urandom_range(0, 5))
         1, 5: begin
            sx = lgia_pkg::COORD_W'($urandom_range(0, 4095));
            sy = lgia_pkg::COORD_W'($urandom_range(0, 4095));
            ex = lgia_pkg::COORD_W'($urandom_range(0, 4095));
            ey = lgia_pkg::COORD_W'($urandom_range(0, 4095));
         end
         2: ex = sx;
         3: ey = sy;
         4: begin
            ex = sx;
            ey = sy;
         end
         default: ;
      endcase
      so = lgia_pkg::OFFSET_W'($urandom);
      eo = lgia_pkg::OFFSET_W'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         so = $urandom_range(0, 1) ? 9'h0FF : 9'h101;
         eo = $urandom_range(0, 1) ? 9'h0FF : 9'h100;
      end
      if ($urandom_range(0, 3) == 0)
         write_csr($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI,
                   lgia_pkg::CSR_DATA_W'($urandom));
      write_gradient(sx, sy, ex, ey, so, eo);
   endtask

   task automatic wait_drained();
      do
         @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_pixels.size() != 0);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct()) begin
            next_req = pending_reqs.pop_front();
            req_valid    <= 1'b1;
            req_pixel_in <= next_req.pixel;
            req_row      <= next_req.row;
            req_column   <= next_req.column;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (!hold_started && accepted_count >= 400) begin
         hold_started = 1'b1;
         hold_left = 90;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !reset && $urandom_range(0, 99) < idle_pct();
      end
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_pixels.push_back(gradient_pixel(gradient, req_pixel_in, req_row,
                                                     req_column));
            accepted_count = accepted_count + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("pixel_out unexpected transaction: expected none, actual %0d",
                      rsp_pixel_out);
               error_count = error_count + 1;
            end else begin
               want_pixel = expected_pixels.pop_front();
               if (rsp_pixel_out !== want_pixel) begin
                  $error("pixel_out mismatch: expected %0d, actual %0d", want_pixel,
                         rsp_pixel_out);
                  error_count = error_count + 1;
               end
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      gradient = '{start_x: 14'sd0, start_y: 14'sd0, end_x: 14'sd1, end_y: 14'sd0,
                   start_offset: 9'sd0, end_offset: 9'sd0};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers at their reset values
      add_req(8'd0, 12'd0, 12'd0);
      add_req(8'd255, 12'd4095, 12'd4095);
      add_req(8'd128, 12'd0, 12'd4095);
      add_req(8'd1, 12'd4095, 12'd0);
      wait_drained();

      // horizontal line, clamping at both ends
      write_gradient(14'd0, 14'd0, 14'd4095, 14'd0, 9'h101, 9'h0FF);
      add_req(8'd0, 12'd0, 12'd0);
      add_req(8'd255, 12'd0, 12'd4095);
      add_req(8'd100, 12'd2000, 12'd2048);
      add_req(8'd255, 12'd4095, 12'd0);
      wait_drained();

      // vertical line
      write_gradient(14'd100, 14'd0, 14'd100, 14'd4000, 9'h0FF, 9'h101);
      add_req(8'd0, 12'd0, 12'd100);
      add_req(8'd200, 12'd2000, 12'd4095);
      add_req(8'd255, 12'd4095, 12'd0);
      wait_drained();

      // coinciding points, start offset of -256, spare indexes ignored
      write_csr(CSR_SPARE_LO, '1);
      write_csr(CSR_SPARE_HI, '1);
      write_gradient(14'h2000, 14'h1FFF, 14'h2000, 14'h1FFF, 9'h100, 9'h0FF);
      add_req(8'd255, 12'd0, 12'd0);
      add_req(8'd10, 12'd4095, 12'd4095);
      add_req(8'd255, 12'd1234, 12'd2345);
      wait_drained();

      // widest span across the coordinate range
      write_gradient(14'h2000, 14'h2000, 14'h1FFF, 14'h1FFF, 9'h0FF, 9'h100);
      add_req(8'd0, 12'd0, 12'd0);
      add_req(8'd255, 12'd4095, 12'd4095);
      add_req(8'd127, 12'd0, 12'd4095);
      add_req(8'd128, 12'd4095, 12'd0);
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         random_gradient();
         for (int n = 0; n < PHASE_ITEMS; n++)
            add_random_req();
         wait_drained();
      end

      repeat (lgia_pkg::PIPE_DEPTH + 4) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         $error("pixel_out missing: expected %0d more transactions, actual 0",
                expected_pixels.size());
         error_count = error_count + 1;
      end
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* linear_gradient_intensity_add.f */
src/lgia_pkg.sv
src/lgia_front.sv
src/lgia_div_step.sv
src/lgia_div.sv
src/linear_gradient_intensity_add.sv
src/lgia_checker.sv
tb/sv/tb_linear_gradient_intensity_add.sv
